// ----- sv/t3ma_pkg.sv -----
// ----------------------------------------------------------------------------
// t3ma_pkg
// Shared types, widths and helpers for the T3 moving average filter.
// ----------------------------------------------------------------------------
package t3ma_pkg;

    localparam int MAX_PERIOD = 1024;

    localparam int SMP_W  = 32;   // Q16.16 sample
    localparam int IDX_W  = 24;
    localparam int PER_W  = 11;
    localparam int VF_W   = 15;
    localparam int UC_W   = 12;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 15;

    localparam int EMA_W  = 52;   // Q16.32 stage value with headroom
    localparam int SEED_W = 60;   // running seed sum
    localparam int CH_W   = 24;   // operand chunk
    localparam int OPA_W  = 3 * CH_W;
    localparam int MULA_W = CH_W + 1;
    localparam int MULC_W = 33;
    localparam int PRD_W  = MULA_W + MULC_W;
    localparam int ACC_W  = 96;
    localparam int FAC_W  = 31;   // Q1.30 factors
    localparam int COEF_W = 32;   // Q5.27 mix coefficients
    localparam int V2_W   = 30;
    localparam int V3_W   = 45;
    localparam int RAW_W  = 50;
    localparam int DIV_W  = 32;

    localparam int FRAC_SH = 30;
    localparam int OUT_SH  = 43;
    localparam int COEF_SH = 15;
    localparam int NSTAGE  = 6;

    localparam logic [CFG_IW-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_VFACTOR  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_UNSTABLE = 2'd2;

    localparam logic [2:0] PH_SKIP = 3'd6;
    localparam logic [2:0] PH_RUN  = 3'd7;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_DRAIN = 9'b000010000,
        ST_APPLY = 9'b000100000,
        ST_POST  = 9'b001000000,
        ST_COEF  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        JOB_EMA,
        JOB_SEED,
        JOB_DOT,
        JOB_V2,
        JOB_V3
    } job_t;

    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        logic [PER_W-1:0] r;
        begin
            r = p;
            if (p == '0)
                r = PER_W'(1);
            else if (p > PER_W'(MAX_PERIOD))
                r = PER_W'(MAX_PERIOD);
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- sv/t3ma_if.sv -----
// ----------------------------------------------------------------------------
// t3ma_if
// Valid/ready channels for sample words in and T3 result words out.
// ----------------------------------------------------------------------------
interface t3ma_in_if import t3ma_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    series_start;

    modport source (output valid, sample, series_start, input ready);
    modport sink   (input valid, sample, series_start, output ready);
endinterface

interface t3ma_out_if import t3ma_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] t3_value;
    logic [IDX_W-1:0]        sample_index;

    modport source (output valid, t3_value, sample_index, input ready);
    modport sink   (input valid, t3_value, sample_index, output ready);
endinterface

// ----- sv/t3_moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// t3_moving_average_filter
// Six cascaded EMAs with seeded warm-up and a four-term output mix, all run
// through one shared 25x33 multiply-accumulate unit under a sequencer.
//
//   channel | dir | handshake        | word
//   din     | in  | valid/ready      | sample, series_start
//   dout    | out | valid/ready      | t3_value, sample_index
//   cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// Every product is three chunk passes of the multiplier; an EMA stage is a load,
// the passes, a drain and an apply, and the output mix sums four products.
// Warm-up words run fewer stages; with period 1 the sample passes unchanged.
// After reset the divides run, then the coefficients; a period write reruns
// the divides, a vfactor write the coefficients; din.ready stays low meanwhile.
// A finished word waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module t3_moving_average_filter import t3ma_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    t3ma_in_if.sink           din,
    t3ma_out_if.source        dout,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [PER_W-1:0] period_reg, period_next;
    logic [VF_W-1:0]  vfac_reg, vfac_next;
    logic [UC_W-1:0]  ucnt_reg, ucnt_next;
    logic             need_div_reg, need_div_next;
    logic             need_coef_reg, need_coef_next;

    logic signed [EMA_W-1:0]  ema_reg [NSTAGE];
    logic signed [EMA_W-1:0]  ema_next [NSTAGE];
    logic signed [SEED_W-1:0] seed_reg, seed_next;
    logic [2:0]               warm_reg, warm_next;
    logic [PER_W-1:0]         pc_reg, pc_next;
    logic [UC_W-1:0]          ul_reg, ul_next;
    logic [IDX_W-1:0]         sidx_reg, sidx_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [2:0]               ph_reg, ph_next;
    logic [2:0]               nst_reg, nst_next;
    logic [2:0]               j_reg, j_next;
    logic signed [EMA_W-1:0]  x_reg, x_next;

    logic [FAC_W-1:0]         k_reg, k_next;
    logic [FAC_W-1:0]         invp_reg, invp_next;
    logic signed [COEF_W-1:0] coef_reg [4];
    logic signed [COEF_W-1:0] coef_next [4];
    logic [V2_W-1:0]          v2_reg, v2_next;
    logic [V3_W-1:0]          v3_reg, v3_next;
    logic [1:0]               cf_reg, cf_next;

    logic signed [OPA_W-1:0]  a_reg, a_next;
    logic signed [MULC_W-1:0] c_reg, c_next;
    logic [1:0]               ch_reg, ch_next;
    logic [1:0]               term_reg, term_next;
    logic signed [PRD_W-1:0]  prod_reg, prod_next;
    logic [1:0]               psh_reg, psh_next;
    logic                     pv_reg, pv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                     dsel_reg, dsel_next;
    logic [4:0]               dcnt_reg, dcnt_next;
    logic [DIV_W-1:0]         dq_reg, dq_next;
    logic [PER_W-1:0]         drem_reg, drem_next;

    logic signed [SMP_W-1:0]  res_reg, res_next;
    logic signed [SMP_W-1:0]  oval_reg, oval_next;
    logic [IDX_W-1:0]         oidx_reg, oidx_next;
    logic                     ovalid_reg, ovalid_next;

    logic [PER_W-1:0]         pe;
    logic [PER_W-1:0]         pe1;
    logic [2:0]               rd_idx;
    logic signed [EMA_W-1:0]  ema_rd;
    logic signed [EMA_W:0]    ema_d;
    logic signed [MULA_W-1:0] chunk;
    logic signed [ACC_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]  acc_r;
    logic signed [47:0]       xv;
    logic                     accept;

    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    assign pe     = eff_period(period_reg);
    assign pe1    = pe + PER_W'(1);
    assign xv     = $signed({din.sample, 16'h0000});
    assign accept = din.valid && din.ready;

    assign din.ready         = (state_reg == ST_IDLE) && !need_div_reg && !need_coef_reg;
    assign dout.valid        = ovalid_reg;
    assign dout.t3_value     = oval_reg;
    assign dout.sample_index = oidx_reg;

    always_comb
    begin
        if (state_reg == ST_POST)
            rd_idx = 3'(ph_reg - 3'd1);
        else if (job_reg == JOB_DOT)
            rd_idx = 3'(3'd5 - {1'b0, term_reg});
        else
            rd_idx = j_reg;
    end

    assign ema_rd = ema_reg[rd_idx];
    assign ema_d  = (EMA_W + 1)'(x_reg) - (EMA_W + 1)'(ema_rd);

    always_comb
    begin
        case (ch_reg)
            2'd0:    chunk = $signed({1'b0, a_reg[CH_W-1:0]});
            2'd1:    chunk = $signed({1'b0, a_reg[2*CH_W-1:CH_W]});
            default: chunk = $signed({a_reg[OPA_W-1], a_reg[OPA_W-1:2*CH_W]});
        endcase
    end

    always_comb
    begin
        case (psh_reg)
            2'd0:    prod_sh = ACC_W'(prod_reg);
            2'd1:    prod_sh = ACC_W'(prod_reg) <<< CH_W;
            default: prod_sh = ACC_W'(prod_reg) <<< (2 * CH_W);
        endcase
    end

    always_comb
    begin
        case (job_reg)
            JOB_EMA, JOB_SEED: acc_r = acc_reg >>> FRAC_SH;
            JOB_DOT:           acc_r = acc_reg >>> OUT_SH;
            default:           acc_r = acc_reg;
        endcase
    end

    always_comb
    begin
        logic [2:0]                warm_e;
        logic [PER_W-1:0]          pc_e;
        logic signed [SEED_W-1:0]  seed_e;
        logic [IDX_W-1:0]          idx_e;
        logic [PER_W-1:0]          pc_p;
        logic [UC_W-1:0]           ul_p;
        logic signed [EMA_W-1:0]   ema_new;
        logic [PER_W:0]            trial;
        logic                      ge;
        logic [PER_W-1:0]          dd;
        logic [DIV_W-1:0]          quo;
        logic signed [RAW_W-1:0]   rv1s;
        logic signed [RAW_W-1:0]   rv2s;
        logic signed [RAW_W-1:0]   rv3;
        logic signed [RAW_W-1:0]   raw;

        state_next     = state_reg;
        job_next       = job_reg;
        period_next    = period_reg;
        vfac_next      = vfac_reg;
        ucnt_next      = ucnt_reg;
        need_div_next  = need_div_reg;
        need_coef_next = need_coef_reg;
        ema_next       = ema_reg;
        seed_next      = seed_reg;
        warm_next      = warm_reg;
        pc_next        = pc_reg;
        ul_next        = ul_reg;
        sidx_next      = sidx_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        nst_next       = nst_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        invp_next      = invp_reg;
        coef_next      = coef_reg;
        v2_next        = v2_reg;
        v3_next        = v3_reg;
        cf_next        = cf_reg;
        a_next         = a_reg;
        c_next         = c_reg;
        ch_next        = ch_reg;
        term_next      = term_reg;
        prod_next      = chunk * c_reg;
        psh_next       = ch_reg;
        pv_next        = (state_reg == ST_MUL);
        acc_next       = pv_reg ? (acc_reg + prod_sh) : acc_reg;
        dsel_next      = dsel_reg;
        dcnt_next      = dcnt_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        res_next       = res_reg;
        oval_next      = oval_reg;
        oidx_next      = oidx_reg;
        ovalid_next    = ovalid_reg && !dout.ready;

        warm_e  = warm_reg;
        pc_e    = pc_reg;
        seed_e  = seed_reg;
        idx_e   = sidx_reg;
        pc_p    = pc_reg + PER_W'(1);
        ul_p    = (ul_reg != '0) ? ul_reg - UC_W'(1) : ul_reg;
        ema_new = ema_rd + EMA_W'(acc_r);

        dd    = dsel_reg ? pe : pe1;
        trial = {drem_reg, dq_reg[DIV_W-1]};
        ge    = (trial >= {1'b0, dd});
        quo   = {dq_reg[DIV_W-2:0], ge};

        rv1s = RAW_W'($signed({1'b0, vfac_reg})) <<< 28;
        rv2s = RAW_W'($signed({1'b0, v2_reg})) <<< 14;
        rv3  = RAW_W'($signed({1'b0, v3_reg}));
        case (cf_reg)
            2'd0:    raw = -rv3;
            2'd1:    raw = ((rv2s + rv3) <<< 1) + (rv2s + rv3);
            2'd2:    raw = -((rv2s <<< 2) + (rv2s <<< 1))
                           - (((rv1s + rv3) <<< 1) + (rv1s + rv3));
            default: raw = (RAW_W'(1) <<< 42) + (rv1s <<< 1) + rv1s + rv3
                           + (rv2s <<< 1) + rv2s;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (need_div_reg)
                begin
                    need_div_next = 1'b0;
                    dsel_next     = 1'b0;
                    dcnt_next     = '0;
                    drem_next     = '0;
                    dq_next       = (DIV_W'(1) << 31) + DIV_W'(pe1 >> 1);
                    state_next    = ST_DIV;
                end
                else if (need_coef_reg)
                begin
                    need_coef_next = 1'b0;
                    job_next       = JOB_V2;
                    term_next      = '0;
                    state_next     = ST_LOAD;
                end
                else if (accept)
                begin
                    if (din.series_start)
                    begin
                        warm_e = '0;
                        pc_e   = '0;
                        seed_e = '0;
                        idx_e  = '0;
                        ul_next = '0;
                        for (int i = 0; i < NSTAGE; i++)
                            ema_next[i] = '0;
                    end
                    warm_next = warm_e;
                    pc_next   = pc_e;
                    seed_next = seed_e;
                    idx_next  = idx_e;
                    sidx_next = (idx_e == '1) ? idx_e : idx_e + IDX_W'(1);
                    ph_next   = warm_e;
                    if (pe == PER_W'(1))
                    begin
                        res_next = din.sample;
                        if (idx_e >= IDX_W'(ucnt_reg))
                            state_next = ST_EMIT;
                    end
                    else if (warm_e == '0)
                    begin
                        seed_next = seed_e + SEED_W'(xv);
                        pc_next   = pc_e + PER_W'(1);
                        if (pc_e + PER_W'(1) >= pe)
                        begin
                            job_next   = JOB_SEED;
                            term_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        x_next     = EMA_W'(xv);
                        j_next     = '0;
                        nst_next   = (warm_e >= PH_SKIP) ? 3'(NSTAGE) : warm_e;
                        job_next   = JOB_EMA;
                        term_next  = '0;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_DIV:
            begin
                drem_next = ge ? PER_W'(trial - {1'b0, dd}) : PER_W'(trial);
                dq_next   = quo;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd31)
                begin
                    if (!dsel_reg)
                    begin
                        k_next    = quo[FAC_W-1:0];
                        dsel_next = 1'b1;
                        dcnt_next = '0;
                        drem_next = '0;
                        dq_next   = (DIV_W'(1) << 30) + DIV_W'(pe >> 1);
                    end
                    else
                    begin
                        invp_next  = quo[FAC_W-1:0];
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LOAD:
            begin
                case (job_reg)
                    JOB_EMA:
                    begin
                        a_next = OPA_W'(ema_d);
                        c_next = $signed({2'b00, k_reg});
                    end
                    JOB_SEED:
                    begin
                        a_next = OPA_W'(seed_reg);
                        c_next = $signed({2'b00, invp_reg});
                    end
                    JOB_DOT:
                    begin
                        a_next = OPA_W'(ema_rd);
                        c_next = MULC_W'(coef_reg[term_reg]);
                    end
                    JOB_V2:
                    begin
                        a_next = OPA_W'($signed({1'b0, vfac_reg}));
                        c_next = MULC_W'($signed({1'b0, vfac_reg}));
                    end
                    default:
                    begin
                        a_next = OPA_W'($signed({1'b0, v2_reg}));
                        c_next = MULC_W'($signed({1'b0, vfac_reg}));
                    end
                endcase
                if (term_reg == '0)
                begin
                    case (job_reg)
                        JOB_EMA, JOB_SEED: acc_next = ACC_ONE <<< (FRAC_SH - 1);
                        JOB_DOT:           acc_next = ACC_ONE <<< (OUT_SH - 1);
                        default:           acc_next = '0;
                    endcase
                end
                ch_next    = '0;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd2)
                begin
                    ch_next = '0;
                    if (job_reg == JOB_DOT && term_reg != 2'd3)
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
                state_next = ST_APPLY;

            ST_APPLY:
            begin
                case (job_reg)
                    JOB_EMA:
                    begin
                        ema_next[j_reg] = ema_new;
                        x_next          = ema_new;
                        term_next       = '0;
                        if (j_reg + 3'd1 < nst_reg)
                        begin
                            j_next     = j_reg + 3'd1;
                            state_next = ST_LOAD;
                        end
                        else
                            state_next = ST_POST;
                    end
                    JOB_SEED:
                    begin
                        ema_next[ph_reg] = EMA_W'(acc_r);
                        seed_next        = SEED_W'(acc_r);
                        pc_next          = '0;
                        term_next        = '0;
                        if (ph_reg < 3'd5)
                        begin
                            warm_next  = ph_reg + 3'd1;
                            state_next = ST_IDLE;
                        end
                        else if (ucnt_reg == '0)
                        begin
                            warm_next  = PH_RUN;
                            job_next   = JOB_DOT;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            warm_next  = PH_SKIP;
                            ul_next    = ucnt_reg;
                            state_next = ST_IDLE;
                        end
                    end
                    JOB_DOT:
                    begin
                        res_next   = sat32(64'(acc_r));
                        state_next = ST_EMIT;
                    end
                    JOB_V2:
                    begin
                        v2_next    = acc_reg[V2_W-1:0];
                        job_next   = JOB_V3;
                        term_next  = '0;
                        state_next = ST_LOAD;
                    end
                    default:
                    begin
                        v3_next    = acc_reg[V3_W-1:0];
                        cf_next    = '0;
                        state_next = ST_COEF;
                    end
                endcase
            end

            ST_POST:
            begin
                term_next = '0;
                if (ph_reg < PH_SKIP)
                begin
                    seed_next = seed_reg + SEED_W'(ema_rd);
                    if (pc_p < pe - PER_W'(1))
                    begin
                        pc_next    = pc_p;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        job_next   = JOB_SEED;
                        state_next = ST_LOAD;
                    end
                end
                else if (ph_reg == PH_SKIP && ul_p != '0)
                begin
                    ul_next    = ul_p;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (ph_reg == PH_SKIP)
                    begin
                        ul_next   = ul_p;
                        warm_next = PH_RUN;
                    end
                    job_next   = JOB_DOT;
                    state_next = ST_LOAD;
                end
            end

            ST_COEF:
            begin
                coef_next[cf_reg] = sat32(64'((raw + RAW_W'(1 << 14)) >>> COEF_SH));
                cf_next = cf_reg + 2'd1;
                if (cf_reg == 2'd3)
                    state_next = ST_IDLE;
            end

            ST_EMIT:
            begin
                if (!ovalid_reg || dout.ready)
                begin
                    oval_next   = res_reg;
                    oidx_next   = idx_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:
                begin
                    period_next   = cfg_data[PER_W-1:0];
                    need_div_next = 1'b1;
                    for (int i = 0; i < NSTAGE; i++)
                        ema_next[i] = '0;
                    seed_next = '0;
                    warm_next = '0;
                    pc_next   = '0;
                    ul_next   = '0;
                    sidx_next = '0;
                end
                REG_VFACTOR:
                begin
                    vfac_next      = cfg_data[VF_W-1:0];
                    need_coef_next = 1'b1;
                end
                REG_UNSTABLE:
                    ucnt_next = cfg_data[UC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_EMA;
            period_reg    <= PER_W'(5);
            vfac_reg      <= VF_W'(11469);
            ucnt_reg      <= '0;
            need_div_reg  <= 1'b1;
            need_coef_reg <= 1'b1;
            for (int i = 0; i < NSTAGE; i++)
                ema_reg[i] <= '0;
            seed_reg      <= '0;
            warm_reg      <= '0;
            pc_reg        <= '0;
            ul_reg        <= '0;
            sidx_reg      <= '0;
            ch_reg        <= '0;
            term_reg      <= '0;
            pv_reg        <= 1'b0;
            dsel_reg      <= 1'b0;
            dcnt_reg      <= '0;
            cf_reg        <= '0;
            j_reg         <= '0;
            nst_reg       <= '0;
            ph_reg        <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            period_reg    <= period_next;
            vfac_reg      <= vfac_next;
            ucnt_reg      <= ucnt_next;
            need_div_reg  <= need_div_next;
            need_coef_reg <= need_coef_next;
            ema_reg       <= ema_next;
            seed_reg      <= seed_next;
            warm_reg      <= warm_next;
            pc_reg        <= pc_next;
            ul_reg        <= ul_next;
            sidx_reg      <= sidx_next;
            ch_reg        <= ch_next;
            term_reg      <= term_next;
            pv_reg        <= pv_next;
            dsel_reg      <= dsel_next;
            dcnt_reg      <= dcnt_next;
            cf_reg        <= cf_next;
            j_reg         <= j_next;
            nst_reg       <= nst_next;
            ph_reg        <= ph_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        x_reg     <= x_next;
        k_reg     <= k_next;
        invp_reg  <= invp_next;
        coef_reg  <= coef_next;
        v2_reg    <= v2_next;
        v3_reg    <= v3_next;
        a_reg     <= a_next;
        c_reg     <= c_next;
        prod_reg  <= prod_next;
        psh_reg   <= psh_next;
        acc_reg   <= acc_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        res_reg   <= res_next;
        oval_reg  <= oval_next;
        oidx_reg  <= oidx_next;
    end

    ap_busy_during_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (need_div_reg || need_coef_reg) |-> !din.ready)
        else $error("ready high while factors are pending");

    ap_prod_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> $past(state_reg == ST_MUL))
        else $error("product valid without a multiply pass");

    ap_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && job_reg == JOB_EMA) |-> (j_reg < nst_reg))
        else $error("EMA stage index beyond chain length");

    ap_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout.valid) |-> $past(state_reg == ST_EMIT))
        else $error("result word appeared outside emit");

endmodule
